[rtl/rle_pkg.sv]
// Shared types, codes and constants of the replication engine.
`timescale 1ns / 1ps

package rle_pkg;

   localparam int LOG_DEPTH_DEF = 32;
   localparam int MAX_PEERS_DEF = 8;
   localparam int CMD_WIDTH_DEF = 32;

   localparam logic [3:0] VOTE_NONE = 4'd8;
   localparam logic [5:0] POS_MAX   = 6'd63;
   localparam logic [3:0] NODE_COUNT_RESET = 4'd3;

   localparam logic [3:0] CSR_OWN_ID     = 4'd0;
   localparam logic [3:0] CSR_NODE_COUNT = 4'd1;

   localparam logic [2:0] REQ_APPEND  = 3'd0;
   localparam logic [2:0] REQ_AE      = 3'd1;
   localparam logic [2:0] REQ_REPLY   = 3'd2;
   localparam logic [2:0] REQ_PREPARE = 3'd3;
   localparam logic [2:0] REQ_ROLE    = 3'd4;

   localparam logic [2:0] RK_ACK    = 3'd0;
   localparam logic [2:0] RK_HEADER = 3'd1;
   localparam logic [2:0] RK_ENTRY  = 3'd2;
   localparam logic [2:0] RK_REPLY  = 3'd3;
   localparam logic [2:0] RK_COMMIT = 3'd4;

   localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
   localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
   localparam logic [1:0] ROLE_LEADER    = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] msg_term;
      logic [2:0]  peer_id;
      logic [5:0]  prev_index;
      logic [31:0] prev_term;
      logic [5:0]  lead_commit;
      logic [31:0] entry_term;
      logic [31:0] entry_command;
      logic        entry_valid;
      logic        rpc_end;
      logic        reply_success;
      logic [1:0]  new_role;
   } rle_req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] out_term;
      logic [5:0]  out_index;
      logic [31:0] out_prev_term;
      logic [5:0]  out_leader_commit;
      logic [31:0] out_entry_term;
      logic [31:0] out_entry_command;
      logic        out_success;
      logic [5:0]  out_commit;
      logic        out_last;
      logic        timer_reset;
      logic [1:0]  out_role;
   } rle_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEC,
      S_AE_CHK,
      S_AE_ENT,
      S_AE_CMP,
      S_AE_APP,
      S_AE_END,
      S_SCAN_N,
      S_SCAN_T,
      S_SCAN_P,
      S_PR_H,
      S_PR_E,
      S_PR_D,
      S_OUT
   } rle_state_type;

endpackage

[rtl/raft_log_replication_engine_core.sv]
// Top level of the replication engine: sequencer, log memory and peer index registers.
`timescale 1ns / 1ps

// One Raft node's log replication engine. Each accepted request item is worked
// through by a small sequencer around one log memory with a single registered
// read port and one peer-index comparator, so the block takes one item at a time
// and holds req_stall high until it is done with an item, which for one with
// results is once its last result sits in the output register. Per item: client
// append and set role decode and emit; an AppendEntries item checks the stored
// previous term at the head of a stream, compares its entry with the log, appends
// it where it is new, and replies on a stream's last item; a prepare on a leader
// emits a header, then reads and emits each entry, and a refused one emits at
// once; a reply on a leader that keeps its term runs the commit scan, which reads
// the term of each index above the commit point, counts the peers holding each
// index of the current term, and stops when one commits or none is left. Each
// result waits in S_OUT while the output register is held by a stall. The log
// stores come out of reset unwritten; the log count guards every read.
// csr_ready is always high; configuration is to be written while the block is idle.
module raft_log_replication_engine_core
   import rle_pkg::*;
#(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF,
   parameter int MAX_PEERS = MAX_PEERS_DEF,
   parameter int CMD_WIDTH = CMD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rle_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rle_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CW = $clog2(LOG_DEPTH + 2);
   localparam int SW = ((CW > 6) ? CW : 6) + 1;
   localparam int PW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

   rle_state_type state_ff, state_in, ret_ff, ret_in;
   rle_req_type   req_ff, req_in;
   rle_rsp_type   pend_ff, pend_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [2:0]    own_id_ff, own_id_in;
   logic [3:0]    node_count_ff, node_count_in;
   logic [1:0]    role_ff, role_in;
   logic [31:0]   term_ff, term_in;
   logic [3:0]    vote_ff, vote_in;
   logic [CW-1:0] log_count_ff, log_count_in;
   logic [CW-1:0] commit_ff, commit_in;
   logic [CW-1:0] next_ff [MAX_PEERS];
   logic [CW-1:0] next_in [MAX_PEERS];
   logic [CW-1:0] match_ff [MAX_PEERS];
   logic [CW-1:0] match_in [MAX_PEERS];
   logic [5:0]    pos_ff, pos_in;
   logic          rej_ff, rej_in;
   logic [CW-1:0] scan_n_ff, scan_n_in;
   logic [3:0]    scan_i_ff, scan_i_in;
   logic [3:0]    scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          ptv_ok_ff, ptv_ok_in;

   // Log memory: one write and one registered read per cycle.
   logic [31:0]          mem_term [LOG_DEPTH];
   logic [CMD_WIDTH-1:0] mem_cmd [LOG_DEPTH];
   logic [31:0]          rd_term_ff;
   logic [CMD_WIDTH-1:0] rd_cmd_ff;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 mem_we;
   logic [31:0]          wr_term;
   logic [CMD_WIDTH-1:0] wr_cmd;

   // Shared decode of the held request.
   logic          is_leader, room, pid_ok, own_ok, out_free;
   logic [PW-1:0] pid_idx, own_idx;
   logic [SW-1:0] pi_w, lcount_w, ae_idx, last_new, lc_w, nc;
   logic [CW-1:0] pr_nx, pr_prev;
   logic [3:0]    voters, majority;
   logic          higher, not_stale;

   assign is_leader = (role_ff == ROLE_LEADER);
   assign room      = (log_count_ff < CW'(LOG_DEPTH));
   assign pid_ok    = (32'(req_ff.peer_id) < MAX_PEERS);
   assign own_ok    = (32'(own_id_ff) < MAX_PEERS);
   assign pid_idx   = PW'(req_ff.peer_id);
   assign own_idx   = PW'(own_id_ff);
   assign pi_w      = SW'(req_ff.prev_index);
   assign lcount_w  = SW'(log_count_ff);
   assign ae_idx    = pi_w + SW'(pos_ff) + SW'(1);
   assign last_new  = pi_w + SW'(pos_ff);
   assign lc_w      = SW'(req_ff.lead_commit);
   assign higher    = (req_ff.msg_term > term_ff);
   assign not_stale = (req_ff.msg_term >= term_ff);
   assign pr_nx     = (next_ff[pid_idx] == '0) ? CW'(1) : next_ff[pid_idx];
   assign pr_prev   = pr_nx - CW'(1);
   assign voters    = (32'(node_count_ff) < MAX_PEERS) ? node_count_ff : 4'(MAX_PEERS);
   assign majority  = (node_count_ff >> 1) + 4'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The commit clamp takes the smallest of the leader's commit, the last new
   // entry and the local log length.
   always_comb begin
      nc = lc_w;
      if (last_new < nc) begin
         nc = last_new;
      end
      if (lcount_w < nc) begin
         nc = lcount_w;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            unique case (req_ff.req_type) inside
               REQ_APPEND, REQ_ROLE: state_in = S_OUT;
               REQ_AE: begin
                  if (pos_ff == '0 && not_stale && pi_w != '0 && pi_w <= lcount_w) begin
                     state_in = S_AE_CHK;
                  end else begin
                     state_in = S_AE_ENT;
                  end
               end
               REQ_REPLY: state_in = (!higher && is_leader) ? S_SCAN_N : S_OUT;
               REQ_PREPARE: state_in = (is_leader && pid_ok) ? S_PR_H : S_OUT;
               default: state_in = S_IDLE;
            endcase
         end
         S_AE_CHK: state_in = S_AE_ENT;
         S_AE_ENT: begin
            if (req_ff.entry_valid && !rej_ff) begin
               state_in = (ae_idx <= lcount_w) ? S_AE_CMP : S_AE_APP;
            end else begin
               state_in = S_AE_END;
            end
         end
         S_AE_CMP: state_in = S_AE_APP;
         S_AE_APP: state_in = S_AE_END;
         S_AE_END: state_in = req_ff.rpc_end ? S_OUT : S_IDLE;
         S_SCAN_N: state_in = (scan_n_ff > commit_ff) ? S_SCAN_T : S_OUT;
         S_SCAN_T: state_in = (rd_term_ff == term_ff) ? S_SCAN_P : S_SCAN_N;
         S_SCAN_P: begin
            if (scan_i_ff < voters) begin
               state_in = S_SCAN_P;
            end else begin
               state_in = (scan_cnt_ff >= majority) ? S_OUT : S_SCAN_N;
            end
         end
         S_PR_H: state_in = S_OUT;
         S_PR_E: state_in = S_PR_D;
         S_PR_D: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      req_in        = req_ff;
      ret_in        = ret_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      own_id_in     = own_id_ff;
      node_count_in = node_count_ff;
      role_in       = role_ff;
      term_in       = term_ff;
      vote_in       = vote_ff;
      log_count_in  = log_count_ff;
      commit_in     = commit_ff;
      next_in       = next_ff;
      match_in      = match_ff;
      pos_in        = pos_ff;
      rej_in        = rej_ff;
      scan_n_in     = scan_n_ff;
      scan_i_in     = scan_i_ff;
      scan_cnt_in   = scan_cnt_ff;
      cur_in        = cur_ff;
      ptv_ok_in     = ptv_ok_ff;
      rd_addr       = AW'(req_ff.prev_index - 6'd1);
      mem_we        = 1'b0;
      wr_addr       = AW'(log_count_ff);
      wr_term       = term_ff;
      wr_cmd        = CMD_WIDTH'(req_ff.entry_command);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ID:     own_id_in = csr_wdata[2:0];
            CSR_NODE_COUNT: node_count_in = csr_wdata[3:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         S_DEC: begin
            pend_in          = '0;
            pend_in.out_last = 1'b1;
            ret_in           = S_IDLE;
            unique case (req_ff.req_type)
               REQ_APPEND: begin
                  pend_in.result_kind = RK_ACK;
                  if (is_leader && room) begin
                     mem_we              = 1'b1;
                     log_count_in        = log_count_ff + CW'(1);
                     pend_in.out_index   = 6'(log_count_ff + CW'(1));
                     pend_in.out_success = 1'b1;
                     if (own_ok) begin
                        match_in[own_idx] = log_count_ff + CW'(1);
                     end
                  end
               end
               REQ_AE: begin
                  if (pos_ff == '0) begin
                     if (!not_stale) begin
                        rej_in = 1'b1;
                     end else begin
                        if (higher) begin
                           term_in = req_ff.msg_term;
                           role_in = ROLE_FOLLOWER;
                           vote_in = VOTE_NONE;
                        end else if (role_ff == ROLE_CANDIDATE) begin
                           role_in = ROLE_FOLLOWER;
                        end
                        // The stored term is compared in S_AE_CHK when it exists.
                        rej_in = (pi_w > lcount_w);
                     end
                  end
               end
               REQ_REPLY: begin
                  pend_in.result_kind = RK_COMMIT;
                  scan_n_in           = log_count_ff;
                  if (higher) begin
                     term_in = req_ff.msg_term;
                     role_in = ROLE_FOLLOWER;
                     vote_in = VOTE_NONE;
                  end else if (is_leader && pid_ok) begin
                     if (req_ff.reply_success) begin
                        if (log_count_ff > match_ff[pid_idx]) begin
                           match_in[pid_idx] = log_count_ff;
                        end
                        next_in[pid_idx] = log_count_ff + CW'(1);
                     end else if (next_ff[pid_idx] > CW'(1)) begin
                        next_in[pid_idx] = next_ff[pid_idx] - CW'(1);
                     end
                  end
               end
               REQ_PREPARE: begin
                  pend_in.result_kind = RK_HEADER;
                  cur_in              = pr_nx;
                  ptv_ok_in           = (pr_prev != '0) && (pr_prev <= log_count_ff);
                  rd_addr             = AW'(pr_prev - CW'(1));
               end
               REQ_ROLE: begin
                  pend_in.result_kind = RK_COMMIT;
                  if (req_ff.new_role == ROLE_CANDIDATE) begin
                     vote_in = {1'b0, own_id_ff};
                  end else if (req_ff.msg_term != term_ff) begin
                     vote_in = VOTE_NONE;
                  end
                  term_in = req_ff.msg_term;
                  role_in = (req_ff.new_role > ROLE_LEADER) ? ROLE_FOLLOWER
                                                            : req_ff.new_role;
                  if (req_ff.new_role == ROLE_LEADER) begin
                     for (int p = 0; p < MAX_PEERS; p++) begin
                        next_in[p]  = log_count_ff + CW'(1);
                        match_in[p] = '0;
                     end
                     if (own_ok) begin
                        match_in[own_idx] = log_count_ff;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_AE_CHK: begin
            rej_in = (rd_term_ff != req_ff.prev_term);
         end
         S_AE_ENT: begin
            rd_addr = AW'(ae_idx - SW'(1));
            if (req_ff.entry_valid && rej_ff) begin
               pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 6'd1;
            end
         end
         S_AE_CMP: begin
            // A conflicting entry drops it and everything after it.
            if (rd_term_ff != req_ff.entry_term) begin
               log_count_in = CW'(ae_idx - SW'(1));
            end
         end
         S_AE_APP: begin
            if (ae_idx == lcount_w + SW'(1) && room) begin
               mem_we       = 1'b1;
               wr_addr      = AW'(ae_idx - SW'(1));
               wr_term      = req_ff.entry_term;
               log_count_in = CW'(ae_idx);
            end
            pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 6'd1;
         end
         S_AE_END: begin
            if (req_ff.rpc_end) begin
               if (!rej_ff && nc > SW'(commit_ff)) begin
                  commit_in = CW'(nc);
               end
               pend_in             = '0;
               pend_in.result_kind = RK_REPLY;
               pend_in.out_index   = 6'(log_count_ff);
               pend_in.out_success = !rej_ff;
               pend_in.out_last    = 1'b1;
               pend_in.timer_reset = not_stale;
               pos_in              = '0;
               rej_in              = 1'b0;
            end
         end
         S_SCAN_N: begin
            rd_addr     = AW'(scan_n_ff - CW'(1));
            scan_i_in   = '0;
            scan_cnt_in = '0;
         end
         S_SCAN_T: begin
            if (rd_term_ff != term_ff) begin
               scan_n_in = scan_n_ff - CW'(1);
            end
         end
         S_SCAN_P: begin
            if (scan_i_ff < voters) begin
               if (match_ff[PW'(scan_i_ff)] >= scan_n_ff) begin
                  scan_cnt_in = scan_cnt_ff + 4'd1;
               end
               scan_i_in = scan_i_ff + 4'd1;
            end else if (scan_cnt_ff >= majority) begin
               commit_in = scan_n_ff;
            end else begin
               scan_n_in = scan_n_ff - CW'(1);
            end
         end
         S_PR_H: begin
            pend_in.out_index         = 6'(cur_ff - CW'(1));
            pend_in.out_prev_term     = ptv_ok_ff ? rd_term_ff : '0;
            pend_in.out_leader_commit = 6'(commit_ff);
            pend_in.out_success       = 1'b1;
            pend_in.out_last          = (cur_ff > log_count_ff);
            ret_in                    = (cur_ff > log_count_ff) ? S_IDLE : S_PR_E;
         end
         S_PR_E: begin
            rd_addr = AW'(cur_ff - CW'(1));
         end
         S_PR_D: begin
            pend_in                   = '0;
            pend_in.result_kind       = RK_ENTRY;
            pend_in.out_index         = 6'(cur_ff);
            pend_in.out_entry_term    = rd_term_ff;
            pend_in.out_entry_command = 32'(rd_cmd_ff);
            pend_in.out_last          = (cur_ff == log_count_ff);
            ret_in                    = (cur_ff == log_count_ff) ? S_IDLE : S_PR_E;
            cur_in                    = cur_ff + CW'(1);
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in            = pend_ff;
               rsp_in.out_term   = term_ff;
               rsp_in.out_commit = 6'(commit_ff);
               rsp_in.out_role   = role_ff;
               rsp_valid_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_term[wr_addr] <= wr_term;
         mem_cmd[wr_addr]  <= wr_cmd;
      end
      rd_term_ff <= mem_term[rd_addr];
      rd_cmd_ff  <= mem_cmd[rd_addr];
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      cur_ff  <= cur_in;
      ptv_ok_ff <= ptv_ok_in;
      scan_n_ff <= scan_n_in;
      scan_i_ff <= scan_i_in;
      scan_cnt_ff <= scan_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         own_id_ff     <= '0;
         node_count_ff <= NODE_COUNT_RESET;
         role_ff       <= ROLE_FOLLOWER;
         term_ff       <= '0;
         vote_ff       <= VOTE_NONE;
         log_count_ff  <= '0;
         commit_ff     <= '0;
         pos_ff        <= '0;
         rej_ff        <= 1'b0;
         for (int p = 0; p < MAX_PEERS; p++) begin
            next_ff[p]  <= '0;
            match_ff[p] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         rsp_valid_ff  <= rsp_valid_in;
         own_id_ff     <= own_id_in;
         node_count_ff <= node_count_in;
         role_ff       <= role_in;
         term_ff       <= term_in;
         vote_ff       <= vote_in;
         log_count_ff  <= log_count_in;
         commit_ff     <= commit_in;
         pos_ff        <= pos_in;
         rej_ff        <= rej_in;
         next_ff       <= next_in;
         match_ff      <= match_in;
      end
   end

endmodule

[rtl/rle_checker.sv]
// Port-level checker of the replication engine and its bind to the top level.
`timescale 1ns / 1ps

module rle_checker
   import rle_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rle_rsp_type rsp_data
);

   // An accepted item always makes the block report busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while block reported idle next cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_ack_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RK_ACK |->
         rsp_data.out_success == (rsp_data.out_index != 6'd0))
      else $error("append ack success does not match index");

   a_entry_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind != RK_ENTRY |->
         rsp_data.out_entry_term == 32'd0 && rsp_data.out_entry_command == 32'd0)
      else $error("entry fields set on a non-entry result");

endmodule

bind raft_log_replication_engine_core rle_checker u_rle_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the Raft log replication engine core.
`timescale 1ns / 1ps

module testbench;
   import rle_pkg::*;

   localparam int LOG_MAX = 32;
   localparam int PEERS = 8;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int HOLDOFF_AT = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rle_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rle_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   raft_log_replication_engine_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Requests waiting to be offered, and the results the node must produce.
   rle_req_type pending_reqs[$];
   rle_rsp_type expected_rsps[$];

   int unsigned error_count = 0;
   int unsigned reqs_accepted = 0;
   int unsigned rsps_checked = 0;
   int unsigned settings_used = 0;
   int unsigned longest_prepare = 0;

   // Mirror of the node: role, term, log, commit point and per-peer indices.
   logic [2:0]  node_own_id;
   logic [3:0]  node_members;
   logic [1:0]  node_role;
   logic [31:0] node_term;
   logic [31:0] log_term_mem[LOG_MAX];
   logic [31:0] log_cmd_mem[LOG_MAX];
   int          log_len;
   int          commit_idx;
   int          peer_nxt[PEERS];
   int          match_idx[PEERS];
   int          stream_pos;
   bit          stream_rejected;

   task automatic report(input string msg);
      $display("testbench: MISMATCH %s", msg);
      error_count++;
   endtask

   // Builds one result from the node state as it stands after the request.
   function automatic rle_rsp_type make_rsp(logic [2:0] kind, int idx, logic [31:0] pterm,
                                            int lcommit, logic [31:0] eterm,
                                            logic [31:0] ecmd, bit succ, bit last,
                                            bit timer);
      rle_rsp_type r;
      r.result_kind       = kind;
      r.out_term          = node_term;
      r.out_index         = idx[5:0];
      r.out_prev_term     = pterm;
      r.out_leader_commit = lcommit[5:0];
      r.out_entry_term    = eterm;
      r.out_entry_command = ecmd;
      r.out_success       = succ;
      r.out_commit        = commit_idx[5:0];
      r.out_last          = last;
      r.timer_reset       = timer;
      r.out_role          = node_role;
      return r;
   endfunction

   // A leader commits the highest current-term index that a majority holds.
   function automatic void scan_for_commit();
      int voters;
      int quorum;
      int n;
      int holders;
      voters = (node_members < PEERS) ? node_members : PEERS;
      quorum = node_members / 2 + 1;
      if (node_role != ROLE_LEADER) return;
      for (n = log_len; n > commit_idx; n--) begin
         if (log_term_mem[n-1] != node_term) continue;
         holders = 0;
         for (int i = 0; i < voters; i++)
            if (match_idx[i] >= n) holders++;
         if (holders >= quorum) begin
            commit_idx = n;
            return;
         end
      end
   endfunction

   // Advances the mirror by one accepted request and queues its results.
   function automatic void apply_request(rle_req_type q);
      int idx;
      int pi;
      int nx;
      int prev;
      int lim;
      bit rej;
      logic [31:0] ptv;
      logic [1:0] nr;
      pi = q.prev_index;
      case (q.req_type)
         REQ_APPEND: begin
            idx = 0;
            if (node_role == ROLE_LEADER && log_len < LOG_MAX) begin
               idx = log_len + 1;
               log_term_mem[idx-1] = node_term;
               log_cmd_mem[idx-1] = q.entry_command;
               log_len = idx;
               match_idx[node_own_id] = idx;
            end
            expected_rsps.push_back(make_rsp(RK_ACK, idx, 0, 0, 0, 0, idx != 0, 1, 0));
         end
         REQ_AE: begin
            // The term and consistency check runs once per stream, at its head.
            if (stream_pos == 0) begin
               rej = 0;
               if (q.msg_term < node_term) begin
                  rej = 1;
               end else begin
                  if (q.msg_term > node_term) begin
                     node_term = q.msg_term;
                     node_role = ROLE_FOLLOWER;
                  end
                  if (node_role == ROLE_CANDIDATE) node_role = ROLE_FOLLOWER;
                  if (pi > 0 && (pi > log_len || log_term_mem[pi-1] != q.prev_term))
                     rej = 1;
               end
               stream_rejected = rej;
            end
            if (q.entry_valid) begin
               if (!stream_rejected) begin
                  idx = pi + stream_pos + 1;
                  if (idx <= log_len && log_term_mem[idx-1] != q.entry_term)
                     log_len = idx - 1;
                  if (idx == log_len + 1 && log_len < LOG_MAX) begin
                     log_term_mem[idx-1] = q.entry_term;
                     log_cmd_mem[idx-1] = q.entry_command;
                     log_len = idx;
                  end
               end
               if (stream_pos < 63) stream_pos++;
            end
            if (q.rpc_end) begin
               if (!stream_rejected && q.lead_commit > commit_idx) begin
                  lim = q.lead_commit;
                  if (lim > pi + stream_pos) lim = pi + stream_pos;
                  if (lim > log_len) lim = log_len;
                  if (lim > commit_idx) commit_idx = lim;
               end
               expected_rsps.push_back(make_rsp(RK_REPLY, log_len, 0, 0, 0, 0,
                                                !stream_rejected, 1,
                                                q.msg_term >= node_term));
               stream_pos = 0;
               stream_rejected = 0;
            end
         end
         REQ_REPLY: begin
            if (q.msg_term > node_term) begin
               node_term = q.msg_term;
               node_role = ROLE_FOLLOWER;
            end else if (node_role == ROLE_LEADER) begin
               if (q.reply_success) begin
                  if (log_len > match_idx[q.peer_id]) match_idx[q.peer_id] = log_len;
                  peer_nxt[q.peer_id] = log_len + 1;
               end else if (peer_nxt[q.peer_id] > 1) begin
                  peer_nxt[q.peer_id]--;
               end
               scan_for_commit();
            end
            expected_rsps.push_back(make_rsp(RK_COMMIT, 0, 0, 0, 0, 0, 0, 1, 0));
         end
         REQ_PREPARE: begin
            if (node_role != ROLE_LEADER) begin
               expected_rsps.push_back(make_rsp(RK_HEADER, 0, 0, 0, 0, 0, 0, 1, 0));
            end else begin
               nx = (peer_nxt[q.peer_id] == 0) ? 1 : peer_nxt[q.peer_id];
               prev = nx - 1;
               ptv = (prev >= 1 && prev <= log_len) ? log_term_mem[prev-1] : '0;
               expected_rsps.push_back(make_rsp(RK_HEADER, prev, ptv, commit_idx, 0, 0, 1,
                                                nx > log_len, 0));
               for (int i = nx; i <= log_len; i++)
                  expected_rsps.push_back(make_rsp(RK_ENTRY, i, 0, 0, log_term_mem[i-1],
                                                   log_cmd_mem[i-1], 0, i == log_len, 0));
               if (log_len - nx + 2 > int'(longest_prepare))
                  longest_prepare = log_len - nx + 2;
            end
         end
         REQ_ROLE: begin
            nr = (q.new_role > ROLE_LEADER) ? ROLE_FOLLOWER : q.new_role;
            node_term = q.msg_term;
            node_role = nr;
            if (nr == ROLE_LEADER) begin
               for (int i = 0; i < PEERS; i++) begin
                  peer_nxt[i] = log_len + 1;
                  match_idx[i] = 0;
               end
               match_idx[node_own_id] = log_len;
            end
            expected_rsps.push_back(make_rsp(RK_COMMIT, 0, 0, 0, 0, 0, 0, 1, 0));
         end
         default: begin
            // Undefined request codes are dropped without a result.
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Every field starts random so unused fields still toggle all their bits.
   function automatic rle_req_type random_req(logic [2:0] kind);
      rle_req_type r;
      r.req_type      = kind;
      r.msg_term      = $urandom;
      r.peer_id       = $urandom_range(0, 7);
      r.prev_index    = $urandom_range(0, 63);
      r.prev_term     = $urandom;
      r.lead_commit   = $urandom_range(0, 63);
      r.entry_term    = $urandom;
      r.entry_command = $urandom;
      r.entry_valid   = $urandom_range(0, 1);
      r.rpc_end       = $urandom_range(0, 1);
      r.reply_success = $urandom_range(0, 1);
      r.new_role      = $urandom_range(0, 3);
      return r;
   endfunction

   function automatic rle_req_type ae_item(logic [31:0] term, int prev, logic [31:0] pterm,
                                           int lcommit, bit has_entry, logic [31:0] eterm,
                                           bit last);
      rle_req_type r;
      r = random_req(REQ_AE);
      r.msg_term      = term;
      r.prev_index    = prev[5:0];
      r.prev_term     = pterm;
      r.lead_commit   = lcommit[5:0];
      r.entry_valid   = has_entry;
      r.entry_term    = eterm;
      r.rpc_end       = last;
      return r;
   endfunction

   function automatic rle_req_type role_item(logic [1:0] nr, logic [31:0] term);
      rle_req_type r;
      r = random_req(REQ_ROLE);
      r.new_role = nr;
      r.msg_term = term;
      return r;
   endfunction

   function automatic rle_req_type peer_item(logic [2:0] kind, logic [2:0] peer, bit ok,
                                             logic [31:0] term);
      rle_req_type r;
      r = random_req(kind);
      r.peer_id = peer;
      r.reply_success = ok;
      r.msg_term = term;
      return r;
   endfunction

   task automatic csr_write(input logic [3:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_OWN_ID) node_own_id = value[2:0];
      else node_members = value[3:0];
   endtask

   // Waits, with all clock-edge updates settled, until every item went out, the
   // block is idle again and every result came back.
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || req_stall ||
             expected_rsps.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] own, input logic [3:0] members);
      csr_write(CSR_OWN_ID, {5'd0, own});
      csr_write(CSR_NODE_COUNT, {4'd0, members});
      settings_used++;
   endtask

   // Follower traffic from a simulated leader whose log is tracked here, so most
   // streams pass the consistency check; a few are stale, inconsistent or out of range.
   task automatic follower_phase(input int streams);
      logic [31:0] lead_log[LOG_MAX];
      logic [31:0] lead_term;
      logic [31:0] stream_term;
      logic [31:0] pterm;
      logic [31:0] eterm;
      int          lead_len;
      int          prev;
      int          n;
      int          pick;
      int          idx;
      bit          broken;
      lead_log = log_term_mem;
      lead_len = log_len;
      lead_term = $urandom_range(1, 5000);
      pending_reqs.push_back(role_item(ROLE_FOLLOWER, lead_term));
      repeat (streams) begin
         pick = $urandom_range(0, 19);
         prev = lead_len - $urandom_range(0, (lead_len < 3) ? lead_len : 3);
         n = $urandom_range(0, 3);
         stream_term = lead_term;
         broken = 0;
         pterm = (prev > 0) ? lead_log[prev-1] : $urandom;
         if (pick == 0) begin
            stream_term = lead_term - 1;
            broken = 1;
         end else if (pick == 1) begin
            if (prev == 0) prev = 1;
            pterm = (prev <= lead_len) ? lead_log[prev-1] ^ (32'd1 << $urandom_range(0, 31))
                                       : $urandom;
            broken = 1;
         end else if (pick == 2) begin
            prev = $urandom_range(lead_len + 1, 63);
            broken = 1;
         end else if (pick == 3) begin
            lead_term++;
            stream_term = lead_term;
         end
         if (n == 0) begin
            pending_reqs.push_back(ae_item(stream_term, prev, pterm,
                                           $urandom_range(0, prev + 2), 0, 0, 1));
         end
         for (int j = 1; j <= n; j++) begin
            idx = prev + j;
            if (idx <= lead_len && $urandom_range(0, 2) != 0) eterm = lead_log[idx-1];
            else if ($urandom_range(0, 5) == 0) eterm = $urandom;
            else eterm = lead_term;
            if (j < n && $urandom_range(0, 4) == 0)
               pending_reqs.push_back(ae_item(stream_term, prev, pterm, 0, 0, 0, 0));
            pending_reqs.push_back(ae_item(stream_term, prev, pterm,
                                           $urandom_range(0, prev + n + 2), 1, eterm, j == n));
            if (!broken) begin
               if (idx <= lead_len && lead_log[idx-1] != eterm) lead_len = idx - 1;
               if (idx == lead_len + 1 && lead_len < LOG_MAX) begin
                  lead_log[idx-1] = eterm;
                  lead_len = idx;
               end
            end
         end
      end
   endtask

   // Leader traffic: appends, peer replies, prepares and the odd disruption.
   task automatic leader_phase(input int count);
      logic [31:0] lead_term;
      int          pick;
      rle_req_type r;
      lead_term = $urandom;
      pending_reqs.push_back(role_item(ROLE_LEADER, lead_term));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            pending_reqs.push_back(random_req(REQ_APPEND));
         end else if (pick < 75) begin
            pending_reqs.push_back(peer_item(REQ_REPLY, $urandom_range(0, 7),
                                             $urandom_range(0, 3) != 0,
                                             (pick == 74) ? lead_term + 1 : lead_term));
         end else if (pick < 95) begin
            pending_reqs.push_back(peer_item(REQ_PREPARE, $urandom_range(0, 7), 0, $urandom));
         end else if (pick < 97) begin
            r = random_req(REQ_APPEND);
            r.req_type = $urandom_range(5, 7);
            pending_reqs.push_back(r);
         end else begin
            pending_reqs.push_back(role_item($urandom_range(0, 3), lead_term));
            pending_reqs.push_back(role_item(ROLE_LEADER, lead_term));
         end
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   logic [2:0] cfg_own[4] = '{3'd2, 3'd5, 3'd1, 3'd4};
   logic [3:0] cfg_members[4] = '{4'd1, 4'd15, 4'd0, 4'd4};

   initial begin
      rle_req_type r;
      node_own_id = 3'd0;
      node_members = NODE_COUNT_RESET;
      node_role = ROLE_FOLLOWER;
      node_term = '0;
      log_len = 0;
      commit_idx = 0;
      stream_pos = 0;
      stream_rejected = 0;
      for (int i = 0; i < PEERS; i++) begin
         peer_nxt[i] = 0;
         match_idx[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      configure(3'd0, 4'd3);

      // Directed: role codes including the out-of-range one, requests a non-leader
      // must refuse, a candidate yielding to a leader, stale terms, a failed
      // consistency check, conflict truncation, a leader round trip and step-down.
      pending_reqs.push_back(role_item(2'd3, 32'd1));
      pending_reqs.push_back(role_item(ROLE_CANDIDATE, 32'd2));
      pending_reqs.push_back(random_req(REQ_APPEND));
      pending_reqs.push_back(peer_item(REQ_PREPARE, 3'd0, 0, 32'd2));
      pending_reqs.push_back(peer_item(REQ_REPLY, 3'd1, 1, 32'd2));
      pending_reqs.push_back(ae_item(32'd2, 0, 32'd0, 0, 0, 0, 1));
      r = ae_item(32'd2, 0, 32'd0, 63, 1, 32'd2, 0);
      r.entry_command = 32'h0000_0000;
      pending_reqs.push_back(r);
      r = ae_item(32'd2, 0, 32'd0, 63, 1, 32'd2, 1);
      r.entry_command = 32'hFFFF_FFFF;
      pending_reqs.push_back(r);
      pending_reqs.push_back(ae_item(32'd1, 0, 32'd0, 2, 0, 0, 1));
      pending_reqs.push_back(ae_item(32'd2, 5, 32'd2, 2, 0, 0, 1));
      pending_reqs.push_back(ae_item(32'd2, 2, 32'd7, 2, 0, 0, 1));
      pending_reqs.push_back(ae_item(32'd3, 1, 32'd2, 2, 1, 32'd3, 1));
      pending_reqs.push_back(role_item(ROLE_LEADER, 32'd4));
      pending_reqs.push_back(random_req(REQ_APPEND));
      pending_reqs.push_back(random_req(REQ_APPEND));
      pending_reqs.push_back(peer_item(REQ_PREPARE, 3'd1, 0, 32'd4));
      pending_reqs.push_back(peer_item(REQ_REPLY, 3'd1, 0, 32'd4));
      pending_reqs.push_back(peer_item(REQ_PREPARE, 3'd1, 0, 32'd4));
      pending_reqs.push_back(peer_item(REQ_REPLY, 3'd1, 1, 32'd4));
      pending_reqs.push_back(peer_item(REQ_REPLY, 3'd2, 1, 32'd5));
      r = random_req(REQ_APPEND);
      r.req_type = 3'd5;
      pending_reqs.push_back(r);
      r.req_type = 3'd7;
      pending_reqs.push_back(r);
      pending_reqs.push_back(role_item(ROLE_FOLLOWER, 32'hFFFF_FFFF));
      pending_reqs.push_back(ae_item(32'hFFFF_FFFF, 0, 32'd0, 0, 0, 0, 1));
      drain();

      // Full log: cut the log back to one entry, take leadership, pull one peer's
      // next index down to 1, fill past the top, then send that peer everything.
      configure(3'd7, 4'd8);
      if (log_len > 0)
         pending_reqs.push_back(ae_item(node_term, 0, 32'd0, 0, 1, log_term_mem[0] + 1, 1));
      pending_reqs.push_back(role_item(ROLE_LEADER, 32'h8000_0001));
      pending_reqs.push_back(peer_item(REQ_REPLY, 3'd3, 0, 32'h8000_0001));
      repeat (LOG_MAX + 1) pending_reqs.push_back(random_req(REQ_APPEND));
      pending_reqs.push_back(peer_item(REQ_PREPARE, 3'd3, 0, 32'd0));
      for (int p = 0; p < 4; p++)
         pending_reqs.push_back(peer_item(REQ_REPLY, p[2:0], 1, 32'h8000_0001));
      drain();

      // Random phases, one per cluster setting; each drain is a full sender pause.
      for (int c = 0; c < 4; c++) begin
         configure(cfg_own[c], cfg_members[c]);
         follower_phase(6);
         leader_phase(16);
         drain();
      end

      $display("testbench: %0d requests accepted, %0d results checked, %0d cluster settings",
               reqs_accepted, rsps_checked, settings_used);
      $display("testbench: longest prepare burst was %0d results", longest_prepare);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------- request driver

   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(req_data);
            reqs_accepted++;
         end
         // A stalled item is held as it is; otherwise pick the next one, or idle.
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result stall

   int holdoff_left = 0;
   bit holdoff_done = 0;
   int stall_mode = 0;
   int mode_cycles = 0;
   int stall_phase = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && reqs_accepted >= HOLDOFF_AT) begin
         // One long hold-off so the block backs up onto its request side.
         holdoff_done = 1;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         mode_cycles++;
         stall_phase++;
         if (mode_cycles >= 64) begin
            mode_cycles = 0;
            stall_mode = $urandom_range(0, 2);
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= (stall_phase % 4) != 0;
         endcase
      end
   end

   // ---------------------------------------------------------------- result checker

   rle_rsp_type want;

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         report($sformatf("%s: got %h, expected %h (result %0d)", name, got, exp_val,
                          rsps_checked));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report($sformatf("result of kind %0d arrived with nothing outstanding",
                             rsp_data.result_kind));
         end else begin
            want = expected_rsps.pop_front();
            check_field("result_kind", rsp_data.result_kind, want.result_kind);
            check_field("out_term", rsp_data.out_term, want.out_term);
            check_field("out_index", rsp_data.out_index, want.out_index);
            check_field("out_prev_term", rsp_data.out_prev_term, want.out_prev_term);
            check_field("out_leader_commit", rsp_data.out_leader_commit,
                        want.out_leader_commit);
            check_field("out_entry_term", rsp_data.out_entry_term, want.out_entry_term);
            check_field("out_entry_command", rsp_data.out_entry_command,
                        want.out_entry_command);
            check_field("out_success", rsp_data.out_success, want.out_success);
            check_field("out_commit", rsp_data.out_commit, want.out_commit);
            check_field("out_last", rsp_data.out_last, want.out_last);
            check_field("timer_reset", rsp_data.timer_reset, want.timer_reset);
            check_field("out_role", rsp_data.out_role, want.out_role);
            rsps_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench: no progress for %0d cycles", IDLE_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[sim.f]
rtl/rle_pkg.sv
rtl/raft_log_replication_engine_core.sv
rtl/rle_checker.sv
tb/sv/testbench.sv
